/* design/hsv_near_match_run_encoder_unit_assert.svh */
// assertion macros for the hsv near-match run encoder
// included by the modules that check their own logic; no other dependencies
`ifndef HSV_NEAR_MATCH_RUN_ENCODER_UNIT_ASSERT_SVH
`define HSV_NEAR_MATCH_RUN_ENCODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define HSVNM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hsvnm assertion failed");
// next-cycle implication
`define HSVNM_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hsvnm assertion failed");
`else
`define HSVNM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define HSVNM_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* design/hsvnm_pkg.sv */
// shared types, constants and color packing functions
// used by the front end, the run queue and the back end
package hsvnm_pkg;

    localparam logic [7:0]  HUE_MAX         = 8'd179;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd20;
    localparam logic [7:0]  MAX_RUN_RESET   = 8'd255;

    // register indexes of the configuration port
    localparam logic CFG_MATCH_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_RUN         = 1'b1;

    // hue * 63 / 179 as multiply by reciprocal, shift 21, exact for hue up to 179
    localparam logic [27:0] HUE_PACK_MUL    = 28'd738108;
    // hue6 * 179 / 63 as multiply by reciprocal, shift 20, exact for hue6 up to 63
    localparam logic [27:0] HUE_UNPACK_MUL  = 28'd2979455;

    // one closed run on its way to the divider
    typedef struct packed {
        logic [15:0] hue_total;
        logic [15:0] sat_total;
        logic [15:0] val_total;
        logic [7:0]  count;
        logic        last;
    } t_run_rec;

    function automatic logic [5:0] pack_hue6(input logic [7:0] hue);
        logic [27:0] prod;
        prod = 28'(hue) * HUE_PACK_MUL;
        return prod[26:21];
    endfunction

    function automatic logic [7:0] unpack_hue(input logic [5:0] hue6);
        logic [27:0] prod;
        prod = 28'(hue6) * HUE_UNPACK_MUL;
        return prod[27:20];
    endfunction

endpackage

/* design/hsv_near_match_run_encoder_unit.sv */
// Pixels are taken one per cycle while the run queue has room; a run's result passes the
// queue write, divider load, 8 divide steps and output register after the edge that accepts
// the pixel closing it. Each closed run holds the shared three-lane divider until its result
// is registered, so short runs fill the run queue and raise full until the divider catches up.
// Reset is synchronous, active low: no run open, queue and output empty,
// match_threshold back to 20 and max_run back to 255.
module hsv_near_match_run_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    input  logic        i_end_of_image,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_packed_mean,
    output logic [7:0]  o_run_length,
    output logic        o_last_run,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic [1:0]          push_num;
    hsvnm_pkg::t_run_rec rec_a;
    hsvnm_pkg::t_run_rec rec_b;
    hsvnm_pkg::t_run_rec q_head;
    logic                q_room;
    logic                q_empty;
    logic                q_pop;

    hsvnm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_hue          (i_hue),
        .i_saturation   (i_saturation),
        .i_brightness   (i_brightness),
        .i_end_of_image (i_end_of_image),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_room       (q_room),
        .o_push_num     (push_num),
        .o_rec_a        (rec_a),
        .o_rec_b        (rec_b)
    );

    hsvnm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (push_num),
        .i_rec_a    (rec_a),
        .i_rec_b    (rec_b),
        .o_room     (q_room),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    hsvnm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_packed_mean (o_packed_mean),
        .o_run_length  (o_run_length),
        .o_last_run    (o_last_run)
    );

endmodule

/* design/hsvnm_front.sv */
// front end: takes pixels, packs them, compares with the run reference and
// keeps the running sums; closed runs go out as records; uses hsvnm_pkg
module hsvnm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_hue,
    input  logic [7:0]        i_saturation,
    input  logic [7:0]        i_brightness,
    input  logic              i_end_of_image,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_q_room,
    output logic [1:0]        o_push_num,
    output hsvnm_pkg::t_run_rec o_rec_a,
    output hsvnm_pkg::t_run_rec o_rec_b
);

    logic [7:0]  r_thr;
    logic [7:0]  r_max_run;

    // stage 0: clamped and packed pixel
    logic        r_s0_valid;
    logic [7:0]  r_s0_hue;
    logic [7:0]  r_s0_sat;
    logic [7:0]  r_s0_val;
    logic        r_s0_eoi;
    logic [5:0]  r_s0_hue6;

    // stage 1: open run
    logic [7:0]  r_run_cnt;
    logic [7:0]  r_ref_hue;
    logic [7:0]  r_ref_sat;
    logic [7:0]  r_ref_val;
    logic [15:0] r_hue_tot;
    logic [15:0] r_sat_tot;
    logic [15:0] r_val_tot;

    logic [7:0]  n_run_cnt;
    logic [7:0]  n_ref_hue;
    logic [7:0]  n_ref_sat;
    logic [7:0]  n_ref_val;
    logic [15:0] n_hue_tot;
    logic [15:0] n_sat_tot;
    logic [15:0] n_val_tot;

    logic        accept;
    logic        s1_fire;
    logic [7:0]  in_hue_clamped;
    logic [7:0]  u_hue;
    logic [7:0]  u_sat;
    logic [7:0]  u_val;
    logic        run_open;
    logic        match;
    logic        extend;
    logic        close_old;
    hsvnm_pkg::t_run_rec rec_old;
    hsvnm_pkg::t_run_rec rec_last;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign s1_fire        = r_s0_valid && i_q_room;
    assign full           = r_s0_valid && !s1_fire;
    assign accept         = push && !full;
    assign in_hue_clamped = (i_hue > hsvnm_pkg::HUE_MAX) ? hsvnm_pkg::HUE_MAX : i_hue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= hsvnm_pkg::THRESHOLD_RESET;
            r_max_run <= hsvnm_pkg::MAX_RUN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsvnm_pkg::CFG_MATCH_THRESHOLD: r_thr     <= i_cfg_data;
                hsvnm_pkg::CFG_MAX_RUN:         r_max_run <= i_cfg_data;
                default:                        r_thr     <= r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (accept) begin
            r_s0_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_hue  <= in_hue_clamped;
            r_s0_sat  <= i_saturation;
            r_s0_val  <= i_brightness;
            r_s0_eoi  <= i_end_of_image;
            r_s0_hue6 <= hsvnm_pkg::pack_hue6(in_hue_clamped);
        end
    end

    always_comb begin
        u_hue     = hsvnm_pkg::unpack_hue(r_s0_hue6);
        u_sat     = {r_s0_sat[7:4], 4'b0000};
        u_val     = {r_s0_val[7:2], 2'b00};
        run_open  = (r_run_cnt != 8'd0);
        match     = (abs_diff(u_hue, r_ref_hue) < r_thr) &&
                    (abs_diff(u_sat, r_ref_sat) < r_thr) &&
                    (abs_diff(u_val, r_ref_val) < r_thr) &&
                    (r_run_cnt < r_max_run);
        extend    = run_open && match;
        close_old = run_open && !match;

        if (extend) begin
            n_run_cnt = r_run_cnt + 8'd1;
            n_ref_hue = r_ref_hue;
            n_ref_sat = r_ref_sat;
            n_ref_val = r_ref_val;
            n_hue_tot = r_hue_tot + 16'(r_s0_hue);
            n_sat_tot = r_sat_tot + 16'(r_s0_sat);
            n_val_tot = r_val_tot + 16'(r_s0_val);
        end else begin
            n_run_cnt = 8'd1;
            n_ref_hue = u_hue;
            n_ref_sat = u_sat;
            n_ref_val = u_val;
            n_hue_tot = 16'(r_s0_hue);
            n_sat_tot = 16'(r_s0_sat);
            n_val_tot = 16'(r_s0_val);
        end

        rec_old.hue_total  = r_hue_tot;
        rec_old.sat_total  = r_sat_tot;
        rec_old.val_total  = r_val_tot;
        rec_old.count      = r_run_cnt;
        rec_old.last       = 1'b0;

        rec_last.hue_total = n_hue_tot;
        rec_last.sat_total = n_sat_tot;
        rec_last.val_total = n_val_tot;
        rec_last.count     = n_run_cnt;
        rec_last.last      = 1'b1;

        // closed run goes first, the final run behind it
        o_rec_a = close_old ? rec_old : rec_last;
        o_rec_b = rec_last;
        if (s1_fire) begin
            o_push_num = {1'b0, close_old} + {1'b0, r_s0_eoi};
        end else begin
            o_push_num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= 8'd0;
        end else if (s1_fire) begin
            r_run_cnt <= r_s0_eoi ? 8'd0 : n_run_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_ref_hue <= n_ref_hue;
            r_ref_sat <= n_ref_sat;
            r_ref_val <= n_ref_val;
            r_hue_tot <= n_hue_tot;
            r_sat_tot <= n_sat_tot;
            r_val_tot <= n_val_tot;
        end
    end

endmodule

/* design/hsvnm_queue.sv */
// short queue of closed runs between front and back end
// takes up to two records a cycle, gives one; uses hsvnm_pkg
`include "hsv_near_match_run_encoder_unit_assert.svh"
module hsvnm_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_num,
    input  hsvnm_pkg::t_run_rec i_rec_a,
    input  hsvnm_pkg::t_run_rec i_rec_b,
    output logic                o_room,
    input  logic                i_pop,
    output logic                o_empty,
    output hsvnm_pkg::t_run_rec o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW:0]   FILL_MAX  = (CW+1)'(DEPTH);

    hsvnm_pkg::t_run_rec r_mem [DEPTH];
    hsvnm_pkg::t_run_rec r_head;
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wr_ptr_b;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW:0]   fill_next;
    logic          push_pair;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : (p + PW'(1));
    endfunction

    assign wr_ptr_b  = next_ptr(r_wr_ptr);
    assign o_room    = (r_count <= CW'(DEPTH - 2));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_head;
    assign fill_next = (CW+1)'(r_count) + (CW+1)'(i_push_num);
    assign push_pair = (i_push_num == 2'd2) && !i_pop;

    always_comb begin
        case (i_push_num)
            2'd1:    n_wr_ptr = wr_ptr_b;
            2'd2:    n_wr_ptr = next_ptr(wr_ptr_b);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_rd_ptr = i_pop ? next_ptr(r_rd_ptr) : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= r_count + CW'(i_push_num) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec_a;
        end
        if (i_push_num == 2'd2) begin
            r_mem[wr_ptr_b] <= i_rec_b;
        end
    end

    // head register tracks the next read slot, taking a record written this cycle directly
    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0 && n_rd_ptr == r_wr_ptr) begin
            r_head <= i_rec_a;
        end else if (i_push_num == 2'd2 && n_rd_ptr == wr_ptr_b) begin
            r_head <= i_rec_b;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    `HSVNM_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, i_push_num != 2'd0, fill_next <= FILL_MAX)
    `HSVNM_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `HSVNM_ASSERT_NXT(a_q_pair_grows, i_clk, i_rst_n, push_pair, r_count == $past(r_count) + CW'(2))

endmodule

/* design/hsvnm_back.sv */
// back end: divides the run sums by the run length, packs the mean and holds
// the result in an output register; uses hsvnm_pkg
`include "hsv_near_match_run_encoder_unit_assert.svh"
module hsvnm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  hsvnm_pkg::t_run_rec i_q_head,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [15:0]         o_packed_mean,
    output logic [7:0]          o_run_length,
    output logic                o_last_run
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_back_state;

    t_back_state r_state;
    logic [2:0]  r_step;
    logic [15:0] r_dsh;
    logic [15:0] r_rem_hue;
    logic [15:0] r_rem_sat;
    logic [15:0] r_rem_val;
    logic [7:0]  r_q_hue;
    logic [7:0]  r_q_sat;
    logic [7:0]  r_q_val;
    logic [7:0]  r_len;
    logic        r_last;
    logic        r_out_valid;
    logic [15:0] r_out_mean;
    logic [7:0]  r_out_len;
    logic        r_out_last;

    logic        ge_hue;
    logic        ge_sat;
    logic        ge_val;
    logic        out_pop;
    logic        out_load;

    // one quotient bit per cycle, all three channels side by side
    assign ge_hue   = (r_rem_hue >= r_dsh);
    assign ge_sat   = (r_rem_sat >= r_dsh);
    assign ge_val   = (r_rem_val >= r_dsh);
    assign out_pop  = pop && r_out_valid;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || out_pop);
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == 3'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_step    <= 3'd7;
            r_dsh     <= {1'b0, i_q_head.count, 7'b0};
            r_rem_hue <= i_q_head.hue_total;
            r_rem_sat <= i_q_head.sat_total;
            r_rem_val <= i_q_head.val_total;
            r_len     <= i_q_head.count;
            r_last    <= i_q_head.last;
        end else if (r_state == S_DIV) begin
            r_step    <= r_step - 3'd1;
            r_dsh     <= {1'b0, r_dsh[15:1]};
            r_rem_hue <= ge_hue ? (r_rem_hue - r_dsh) : r_rem_hue;
            r_rem_sat <= ge_sat ? (r_rem_sat - r_dsh) : r_rem_sat;
            r_rem_val <= ge_val ? (r_rem_val - r_dsh) : r_rem_val;
            r_q_hue   <= {r_q_hue[6:0], ge_hue};
            r_q_sat   <= {r_q_sat[6:0], ge_sat};
            r_q_val   <= {r_q_val[6:0], ge_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean <= {hsvnm_pkg::pack_hue6(r_q_hue), r_q_sat[7:4], r_q_val[7:2]};
            r_out_len  <= r_len;
            r_out_last <= r_last;
        end
    end

    assign empty         = !r_out_valid;
    assign o_packed_mean = r_out_mean;
    assign o_run_length  = r_out_len;
    assign o_last_run    = r_out_last;

    `HSVNM_ASSERT_IMP(a_bk_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dsh != 16'd0)
    `HSVNM_ASSERT_IMP(a_bk_hue_range, i_clk, i_rst_n, r_state == S_DONE, r_q_hue <= hsvnm_pkg::HUE_MAX)
    `HSVNM_ASSERT_IMP(a_bk_len_nonzero, i_clk, i_rst_n, r_out_valid, r_out_len != 8'd0)

endmodule
